// ----- sv/dsms_pkg.sv -----
// ----------------------------------------------------------------------------
// dsms_pkg
// Shared types and constants of the dynamic sequence max-subarray block:
// item payloads, command codes, result codes and cell control.
// ----------------------------------------------------------------------------
package dsms_pkg;

  // Default number of stored elements
  localparam int unsigned DEF_CAPACITY = 1024;

  // Fixed field widths
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned POS_W     = 11;
  localparam int unsigned OPND_W    = 16;
  localparam int unsigned SUM_OUT_W = 26;
  localparam int unsigned STATUS_W  = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT  = 2'd0,
    KIND_DELETE  = 2'd1,
    KIND_REPLACE = 2'd2,
    KIND_QUERY   = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_POS = 2'd1,
    STATUS_FULL    = 2'd2
  } status_e;

  // Input item
  typedef struct packed {
    kind_e                     kind;
    logic [POS_W-1:0]          position;
    logic signed [OPND_W-1:0]  operand;
  } dsms_in_t;

  // Result item
  typedef struct packed {
    logic signed [SUM_OUT_W-1:0] best_sum;
    status_e                     status;
  } dsms_out_t;

  // Per-cycle command broadcast along the row of cells
  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_INSERT = 3'd1,
    CELL_DELETE = 3'd2,
    CELL_WRITE  = 3'd3,
    CELL_ROTATE = 3'd4
  } cell_op_e;

  typedef struct packed {
    cell_op_e                 op;
    logic signed [OPND_W-1:0] value;
  } cell_cmd_t;

  // Control of the running max-subarray accumulator
  typedef struct packed {
    logic en;     // element at the head is inside the range
    logic first;  // element at the head opens the range
  } scan_ctl_t;

endpackage

// ----- sv/dsms_chan_if.sv -----
// ----------------------------------------------------------------------------
// dsms_chan_if
// Valid/ready channel carrying one item of type T per handshake.
// ----------------------------------------------------------------------------
interface dsms_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/dsms_cell.sv -----
// ----------------------------------------------------------------------------
// dsms_cell
// One storage cell of the element row. Holds one element and takes its
// neighbor's value to shift, or the broadcast value to write.
// ----------------------------------------------------------------------------
module dsms_cell #(
  parameter int unsigned IDX_W = 10,
  parameter int unsigned INDEX = 0
) (
  input  logic                              clk_i,
  input  dsms_pkg::cell_cmd_t               cmd_i,
  input  logic [IDX_W-1:0]                  idx_i,
  input  logic signed [dsms_pkg::OPND_W-1:0] left_i,
  input  logic signed [dsms_pkg::OPND_W-1:0] right_i,
  output logic signed [dsms_pkg::OPND_W-1:0] value_o
);
  import dsms_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic signed [OPND_W-1:0] value_q, value_d;
  logic                     at_idx;
  logic                     past_idx;

  assign at_idx   = (idx_i == MY_IDX);
  assign past_idx = (MY_IDX > idx_i);

  // Pick the next element for this cell
  always_comb begin
    value_d = value_q;
    unique case (cmd_i.op)
      CELL_HOLD: value_d = value_q;
      CELL_INSERT: begin
        if (past_idx) begin
          value_d = left_i;
        end else if (at_idx) begin
          value_d = cmd_i.value;
        end
      end
      CELL_DELETE: begin
        if (at_idx || past_idx) begin
          value_d = right_i;
        end
      end
      CELL_WRITE: begin
        if (at_idx) begin
          value_d = cmd_i.value;
        end
      end
      CELL_ROTATE: value_d = right_i;
      default: value_d = value_q;
    endcase
  end

  // Hold the element
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

// ----- sv/dsms_scan.sv -----
// ----------------------------------------------------------------------------
// dsms_scan
// Running max-subarray accumulator. Takes one element per cycle from the
// head of the cell row and keeps the best run sum, saturated on output.
// ----------------------------------------------------------------------------
module dsms_scan #(
  parameter int unsigned SUM_W = 27
) (
  input  logic                                 clk_i,
  input  dsms_pkg::scan_ctl_t                  ctl_i,
  input  logic signed [dsms_pkg::OPND_W-1:0]    value_i,
  output logic signed [dsms_pkg::SUM_OUT_W-1:0] best_o
);
  import dsms_pkg::*;

  logic signed [SUM_W-1:0] run_q, run_d;
  logic signed [SUM_W-1:0] best_q, best_d;
  logic signed [SUM_W-1:0] value_ext;

  assign value_ext = SUM_W'(value_i);

  // Extend or restart the current run, then track the best
  always_comb begin
    run_d  = run_q;
    best_d = best_q;
    if (ctl_i.en) begin
      if (ctl_i.first) begin
        run_d  = value_ext;
        best_d = value_ext;
      end else begin
        run_d  = (run_q > 0) ? run_q + value_ext : value_ext;
        best_d = (run_d > best_q) ? run_d : best_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    run_q  <= run_d;
    best_q <= best_d;
  end

  // Clamp to the result width
  if (SUM_W > SUM_OUT_W) begin : g_sat
    localparam logic signed [SUM_W-1:0] HI = SUM_W'((2 ** (SUM_OUT_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] LO = -HI - SUM_W'(1);
    always_comb begin
      if (best_q > HI) begin
        best_o = SUM_OUT_W'(HI);
      end else if (best_q < LO) begin
        best_o = SUM_OUT_W'(LO);
      end else begin
        best_o = SUM_OUT_W'(best_q);
      end
    end
  end else begin : g_ext
    assign best_o = SUM_OUT_W'(best_q);
  end

endmodule

// ----- sv/dynamic_sequence_max_subarray.sv -----
// ----------------------------------------------------------------------------
// dynamic_sequence_max_subarray
// Ordered sequence store with insert, delete, replace and range
// maximum-subarray queries, built as a circular row of element cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_i takes one item per valid/ready handshake: kind, 1-based position
//   and operand. out_o returns exactly one result per item: best_sum and
//   status, in item order.
//   Insert, delete and replace act on all cells at once; the result is
//   presented in the cycle after the item is accepted. A failed check
//   (bad position, empty or reversed range, full store) answers alike.
//   A valid query rotates the whole row once through cell 0, one step per
//   cycle, feeding the max-subarray accumulator; when the rotation ends,
//   the best sum is loaded into the output register once it is free. The
//   rotation length sets the query rate.
//   in_i.ready is high when no query is in flight and the output register is
//   free or being emptied in the same cycle, so an item can be taken while
//   the previous result is handed over. A stalled receiver holds the result
//   and blocks the next item until it is taken.
//   Reset empties the sequence (length zero) and drops any pending result;
//   cell contents are not cleared, since only positions 1..length are read.
// ----------------------------------------------------------------------------
module dynamic_sequence_max_subarray #(
  parameter int unsigned CAPACITY = dsms_pkg::DEF_CAPACITY
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dsms_chan_if.sink   in_i,
  dsms_chan_if.source out_o
);
  import dsms_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned LEN_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = ((LEN_W > OPND_W) ? LEN_W : OPND_W) + 1;
  localparam int unsigned SUM_W = OPND_W + IDX_W + 1;
  localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'(CAPACITY - 1);
  localparam logic [LEN_W-1:0] FULL_LEN  = LEN_W'(CAPACITY);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e                    state_q, state_d;
  logic [LEN_W-1:0]          length_q, length_d;
  logic [IDX_W-1:0]          step_q, step_d;
  logic [IDX_W-1:0]          first_q, first_d;
  logic [IDX_W-1:0]          last_q, last_d;
  logic                      out_valid_q, out_valid_d;
  logic signed [SUM_OUT_W-1:0] out_sum_q;
  status_e                   out_status_q;

  logic                      out_free;
  logic                      in_ready;
  logic                      accept;
  logic                      load_out;
  logic signed [SUM_OUT_W-1:0] load_sum;
  status_e                   load_status;

  logic [CMP_W-1:0]          pos_w;
  logic [CMP_W-1:0]          len_w;
  logic [CMP_W-1:0]          opnd_w;
  logic                      pos_zero;
  logic                      ins_bad;
  logic                      rw_bad;
  logic                      query_bad;
  logic                      is_full;
  logic                      ins_ok;
  logic [IDX_W-1:0]          pos_idx;

  cell_cmd_t                 cmd;
  scan_ctl_t                 scan_ctl;
  logic signed [SUM_OUT_W-1:0] scan_best;
  logic signed [OPND_W-1:0]  cell_val [CAPACITY];

  // Handshake
  assign out_free    = !out_valid_q || out_o.ready;
  assign in_ready    = (state_q == ST_IDLE) && out_free;
  assign in_i.ready  = in_ready;
  assign accept      = in_i.valid && in_ready;

  // Position checks against the current length
  assign pos_w     = CMP_W'(in_i.data.position);
  assign len_w     = CMP_W'(length_q);
  assign opnd_w    = CMP_W'(in_i.data.operand[OPND_W-2:0]);
  assign pos_zero  = (pos_w == '0);
  assign ins_bad   = pos_zero || (pos_w > len_w + CMP_W'(1));
  assign rw_bad    = pos_zero || (pos_w > len_w);
  assign query_bad = pos_zero || in_i.data.operand[OPND_W-1] ||
                     (opnd_w > len_w) || (opnd_w < pos_w);
  assign is_full   = (length_q == FULL_LEN);
  assign pos_idx   = IDX_W'(pos_w - CMP_W'(1));
  assign ins_ok    = accept && (in_i.data.kind == KIND_INSERT) && !ins_bad && !is_full;

  // Feed the accumulator while the range passes cell 0
  assign scan_ctl.en    = (state_q == ST_SCAN) && (step_q >= first_q) && (step_q <= last_q);
  assign scan_ctl.first = (step_q == first_q);

  // Sequence control
  always_comb begin
    state_d     = state_q;
    length_d    = length_q;
    step_d      = step_q;
    first_d     = first_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_o.ready;
    load_out    = 1'b0;
    load_sum    = '0;
    load_status = STATUS_OK;
    cmd.op      = CELL_HOLD;
    cmd.value   = in_i.data.operand;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_i.data.kind)
            KIND_INSERT: begin
              load_out = 1'b1;
              if (ins_bad) begin
                load_status = STATUS_BAD_POS;
              end else if (is_full) begin
                load_status = STATUS_FULL;
              end else begin
                cmd.op   = CELL_INSERT;
                length_d = length_q + LEN_W'(1);
              end
            end
            KIND_DELETE: begin
              load_out = 1'b1;
              if (rw_bad) begin
                load_status = STATUS_BAD_POS;
              end else begin
                cmd.op   = CELL_DELETE;
                length_d = length_q - LEN_W'(1);
              end
            end
            KIND_REPLACE: begin
              load_out = 1'b1;
              if (rw_bad) begin
                load_status = STATUS_BAD_POS;
              end else begin
                cmd.op = CELL_WRITE;
              end
            end
            KIND_QUERY: begin
              if (query_bad) begin
                load_out    = 1'b1;
                load_status = STATUS_BAD_POS;
              end else begin
                state_d = ST_SCAN;
                step_d  = '0;
                first_d = pos_idx;
                last_d  = IDX_W'(opnd_w - CMP_W'(1));
              end
            end
            default: load_out = 1'b0;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.op = CELL_ROTATE;
        if (step_q == LAST_CELL) begin
          step_d  = '0;
          state_d = ST_DONE;
        end else begin
          step_d = step_q + IDX_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load_out = 1'b1;
          load_sum = scan_best;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  // Hold state, length, scan step and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      length_q    <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      length_q    <= length_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture range bounds and result payload
  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    last_q  <= last_d;
    if (load_out) begin
      out_sum_q    <= load_sum;
      out_status_q <= load_status;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.data.best_sum = out_sum_q;
  assign out_o.data.status   = out_status_q;

  // Circular row of element cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    dsms_cell #(
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .idx_i   (pos_idx),
      .left_i  (cell_val[(i + CAPACITY - 1) % CAPACITY]),
      .right_i (cell_val[(i + 1) % CAPACITY]),
      .value_o (cell_val[i])
    );
  end

  dsms_scan #(
    .SUM_W (SUM_W)
  ) u_scan (
    .clk_i   (clk_i),
    .ctl_i   (scan_ctl),
    .value_i (cell_val[0]),
    .best_o  (scan_best)
  );

  // Length never exceeds the capacity
  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    length_q <= FULL_LEN)
    else $error("length above capacity");

  // Non-query items answer in the next cycle
  a_quick_answer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_i.data.kind != KIND_QUERY)) |=> out_valid_q)
    else $error("missing result after update item");

  // No item is taken while the row rotates
  a_scan_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !in_ready)
    else $error("item accepted during scan");

  // A successful insert grows the sequence by one
  a_insert_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_ok |=> (length_q == LEN_W'($past(length_q) + LEN_W'(1))))
    else $error("insert did not grow length");

endmodule
